FILE: sv/rhs_pkg.sv
// Shared types and constants of the rich header scanner.
// Markers, item kinds, scan phases and the result record.
// No dependencies.
package rhs_pkg;

	localparam logic [31:0] END_MARK   = 32'h6863_6952;
	localparam logic [31:0] START_MARK = 32'h536E_6144;
	localparam logic [15:0] PAIR_BYTES = 16'd8;
	localparam logic [63:0] DOS_HDR    = 64'd64;

	// Result queue geometry
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Configuration register indexes
	localparam logic CFG_BASE_ADDRESS = 1'b0;
	localparam logic CFG_STUB_LENGTH  = 1'b1;

	typedef enum logic [2:0] {
		KIND_PAD   = 3'd0,
		KIND_MASK  = 3'd1,
		KIND_ENTRY = 3'd2,
		KIND_START = 3'd3,
		KIND_STUB  = 3'd4
	} item_kind_t;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'b001,
		PH_DECODE = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef struct packed {
		logic        start_of_image;
		logic [31:0] upper_word;
		logic [31:0] lower_word;
	} pair_t;

	typedef struct packed {
		item_kind_t  item_kind;
		logic [31:0] count_value;
		logic [31:0] product_id;
		logic [63:0] item_address;
		logic [15:0] item_length;
		logic        scan_done;
		logic        image_valid;
	} result_t;

	// Results of one pair, handed from the decoder to the result queue
	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

FILE: sv/rhs_if.sv
// Channel interfaces of the rich header scanner: word pairs in, items out.
// Valid/ready handshake; no package dependency.
interface rhs_pair_if;
	logic        valid;
	logic        ready;
	logic        start_of_image;
	logic [31:0] upper_word;
	logic [31:0] lower_word;

	modport source (output valid, start_of_image, upper_word, lower_word, input ready);
	modport sink   (input valid, start_of_image, upper_word, lower_word, output ready);
endinterface

interface rhs_item_if;
	logic        valid;
	logic        ready;
	logic [2:0]  item_kind;
	logic [31:0] count_value;
	logic [31:0] product_id;
	logic [63:0] item_address;
	logic [15:0] item_length;
	logic        scan_done;
	logic        image_valid;

	modport source (output valid, item_kind, count_value, product_id, item_address,
		item_length, scan_done, image_valid, input ready);
	modport sink   (input valid, item_kind, count_value, product_id, item_address,
		item_length, scan_done, image_valid, output ready);
endinterface

FILE: sv/rhs_decode.sv
// Scan state and per-pair decode of the rich header scanner.
// Uses rhs_pkg for markers, phases and the result record.
module rhs_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  rhs_pkg::pair_t   pair_s1,
	input  logic [63:0]      base_address,
	input  logic [15:0]      stub_length,
	output rhs_pkg::push_t   push
);

	rhs_pkg::phase_t phase_q, phase_e, phase_d;
	logic [15:0] off_q, off_e, off_d, off_n;
	logic [31:0] mask_q, mask_e, mask_d;
	logic [1:0]  dp_q, dp_e, dp_d;
	logic        paz_q, paz_e, paz_d;
	logic [31:0] c, p;
	logic [63:0] addr;
	logic        last, ok;
	logic [1:0]  n;
	rhs_pkg::result_t r0, r1;

	always_comb begin
		// start of image restarts the scan before the pair is looked at
		phase_e = pair_s1.start_of_image ? rhs_pkg::PH_SEARCH : phase_q;
		off_e   = pair_s1.start_of_image ? stub_length : off_q;
		mask_e  = pair_s1.start_of_image ? 32'd0 : mask_q;
		dp_e    = pair_s1.start_of_image ? 2'd0 : dp_q;
		paz_e   = pair_s1.start_of_image ? 1'b0 : paz_q;

		phase_d = phase_e;
		off_d   = off_e;
		mask_d  = mask_e;
		dp_d    = dp_e;
		paz_d   = paz_e;

		off_n = off_e - rhs_pkg::PAIR_BYTES;
		addr  = base_address + rhs_pkg::DOS_HDR + {48'd0, off_n};
		last  = off_n < rhs_pkg::PAIR_BYTES;
		c     = pair_s1.upper_word ^ mask_e;
		p     = pair_s1.lower_word ^ mask_e;
		ok    = 1'b0;
		n     = 2'd0;

		r0.item_kind    = rhs_pkg::KIND_PAD;
		r0.count_value  = pair_s1.upper_word;
		r0.product_id   = pair_s1.lower_word;
		r0.item_address = addr;
		r0.item_length  = rhs_pkg::PAIR_BYTES;
		r0.scan_done    = last;
		r0.image_valid  = 1'b0;

		r1.item_kind    = rhs_pkg::KIND_STUB;
		r1.count_value  = 32'd0;
		r1.product_id   = 32'd0;
		r1.item_address = base_address + rhs_pkg::DOS_HDR;
		r1.item_length  = off_n;
		r1.scan_done    = 1'b1;
		r1.image_valid  = 1'b1;

		if (off_e >= rhs_pkg::PAIR_BYTES) begin
			case (phase_e)
				rhs_pkg::PH_SEARCH: begin
					off_d = off_n;
					n     = 2'd1;
					if (pair_s1.lower_word == rhs_pkg::END_MARK) begin
						r0.item_kind = rhs_pkg::KIND_MASK;
						mask_d       = pair_s1.upper_word;
						phase_d      = rhs_pkg::PH_DECODE;
					end
					if (last)
						phase_d = rhs_pkg::PH_DONE;
				end
				rhs_pkg::PH_DECODE: begin
					off_d          = off_n;
					r0.count_value = c;
					r0.product_id  = p;
					if (p == rhs_pkg::START_MARK) begin
						ok = (dp_e != 2'd0) && paz_e && (mask_e != 32'd0) && (c == 32'd0);
						phase_d = rhs_pkg::PH_DONE;
						r0.item_kind = rhs_pkg::KIND_START;
						if (ok && off_n != 16'd0) begin
							r0.scan_done = 1'b0;
							n = 2'd2;
						end else begin
							r0.scan_done   = 1'b1;
							r0.image_valid = ok;
							n = 2'd1;
						end
					end else begin
						r0.item_kind = rhs_pkg::KIND_ENTRY;
						if (dp_e != 2'd3)
							dp_d = dp_e + 2'd1;
						paz_d = (c == 32'd0) && (p == 32'd0);
						if (last)
							phase_d = rhs_pkg::PH_DONE;
						n = 2'd1;
					end
				end
				default: begin
					// scan closed: drop the pair
					n = 2'd0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rhs_pkg::PH_SEARCH;
			off_q   <= 16'd0;
			mask_q  <= 32'd0;
			dp_q    <= 2'd0;
			paz_q   <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			off_q   <= off_d;
			mask_q  <= mask_d;
			dp_q    <= dp_d;
			paz_q   <= paz_d;
		end
	end

	assign push.n  = fire ? n : 2'd0;
	assign push.r0 = r0;
	assign push.r1 = r1;

endmodule

FILE: sv/rhs_result_queue.sv
// Four-entry result queue of the rich header scanner; takes up to two
// results a cycle and drives the item channel. Uses rhs_pkg and rhs_item_if.
module rhs_result_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  rhs_pkg::push_t push,
	output logic           room,
	rhs_item_if.source     item
);

	rhs_pkg::result_t mem_q [rhs_pkg::QDEPTH];
	logic [rhs_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_p1;
	logic [rhs_pkg::QCNT_W-1:0] count_q;
	logic pop;
	rhs_pkg::result_t head;

	assign wr_ptr_p1 = wr_ptr_q + 1'b1;
	assign pop       = (count_q != '0) && item.ready;
	assign room      = count_q <= rhs_pkg::QCNT_W'(rhs_pkg::QDEPTH - 2);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_ptr_q] <= push.r0;
		if (push.n == 2'd2)
			mem_q[wr_ptr_p1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + rhs_pkg::QPTR_W'(push.n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + rhs_pkg::QCNT_W'(push.n) - rhs_pkg::QCNT_W'(pop);
		end
	end

	assign item.valid        = count_q != '0;
	assign item.item_kind    = head.item_kind;
	assign item.count_value  = head.count_value;
	assign item.product_id   = head.product_id;
	assign item.item_address = head.item_address;
	assign item.item_length  = head.item_length;
	assign item.scan_done    = head.scan_done;
	assign item.image_valid  = head.image_valid;

endmodule

FILE: sv/rich_header_scanner.sv
// Top level of the rich header scanner: configuration registers, pair input
// register, decoder and result queue. Uses rhs_pkg, rhs_if, rhs_decode, rhs_result_queue.
//
//   channel | dir | handshake          | carries
//   --------+-----+--------------------+------------------------------------------
//   pair    | in  | valid/ready        | start_of_image, upper_word, lower_word
//   result  | out | valid/ready        | kind, count, product id, address, length,
//           |     |                    | scan_done, image_valid
//   cfg     | in  | cfg_we (no ready)  | cfg_index, cfg_wdata (64 bits)
//
// One pair per cycle while the queue has room. A pair is held in the input register,
// is decoded and written into the four-entry result queue, from which its first
// result is then offered.
// A start marker followed by a stub gives two results.
// The input register advances only while the queue has room for two results,
// so output stalls back up into pair.ready. Reset clears scan state and queue.
module rich_header_scanner (
	input  logic         clk,
	input  logic         arst_n,
	rhs_pair_if.sink     pair,
	rhs_item_if.source   result,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [63:0]  cfg_wdata
);

	logic [63:0]     base_q;
	logic [15:0]     stub_q;
	rhs_pkg::pair_t  pair_s1;
	logic            v_s1;
	logic            room;
	logic            fire;
	rhs_pkg::push_t  push;

	// configuration writes land immediately
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 64'd0;
			stub_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				rhs_pkg::CFG_BASE_ADDRESS: base_q <= cfg_wdata;
				rhs_pkg::CFG_STUB_LENGTH:  stub_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// input register: advance into the decoder whenever the queue has room
	assign fire       = v_s1 && room;
	assign pair.ready = !v_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (pair.valid && pair.ready)
			v_s1 <= 1'b1;
		else if (fire)
			v_s1 <= 1'b0;
	end

	// payload register: hold while stalled
	always_ff @(posedge clk) begin
		if (pair.valid && pair.ready) begin
			pair_s1.start_of_image <= pair.start_of_image;
			pair_s1.upper_word     <= pair.upper_word;
			pair_s1.lower_word     <= pair.lower_word;
		end
	end

	rhs_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.pair_s1      (pair_s1),
		.base_address (base_q),
		.stub_length  (stub_q),
		.push         (push)
	);

	rhs_result_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.item   (result)
	);

	// a second result in one transaction is always the closing stub item
	a_two_results_stub: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.r1.scan_done && push.r1.item_kind == rhs_pkg::KIND_STUB)
		else $error("second result of a pair is not a closing stub item");

	// nothing is pushed without a pair in the input register
	a_push_needs_pair: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> v_s1 && room)
		else $error("result pushed without a pending pair");

	// a stalled input register keeps its pair
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !room |=> v_s1 && $stable(pair_s1))
		else $error("input register lost a pair while stalled");

	// a verdict only rides on the last result of a scan
	a_verdict_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.image_valid |-> result.scan_done)
		else $error("image_valid set on a result that does not close the scan");

endmodule

FILE: sim/rich_header_scanner_test.sv
// Self-checking testbench for rich_header_scanner: directed table, then random images.
// Predicts result items from accepted pairs or hand-typed rows; compares field by field.
// Depends on rhs_pkg, rhs_if and the rich_header_scanner RTL.
module rich_header_scanner_test;
	import rhs_pkg::*;

	localparam int RANDOM_PAIRS   = 1700;
	localparam int DRAIN_CYCLES   = 8;
	localparam int TAIL_CYCLES    = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [31:0] DIR_KEY = 32'h1234_5678;

	// One pair to offer, with an optional hand-typed outcome that replaces the prediction
	typedef struct packed {
		pair_t      pr;
		bit         has_typed;
		bit [1:0]   typed_n;
		result_t    typed_res;
	} stim_t;

	// Directed table row: either a register setting or a pair
	typedef struct packed {
		bit          is_cfg;
		logic [63:0] base;
		logic [15:0] stub;
		stim_t       st;
	} row_t;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_COIN,
		SINK_MOSTLY,
		SINK_CHOKE
	} sink_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = CFG_BASE_ADDRESS;
	logic [63:0] cfg_wdata = 64'd0;
	logic        take_ready = 1'b0;

	rhs_pair_if pair_ch ();
	rhs_item_if item_ch ();

	assign item_ch.ready = take_ready;

	rich_header_scanner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pair     (pair_ch),
		.result   (item_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial forever #5 clk = ~clk;

	// Shadow of the registers and of the scan state
	logic [63:0] load_base;
	logic [15:0] stub_bytes;
	phase_t      scan_phase;
	logic [15:0] bytes_left;
	logic [31:0] scan_key;
	logic [1:0]  entry_count;
	logic        last_entry_zero;

	result_t items_due[$];
	stim_t   offered_stims[$];
	pair_t   image_pairs[$];

	int pairs_taken      = 0;
	int productive_pairs = 0;
	int items_checked    = 0;
	int mismatches       = 0;
	int config_writes    = 0;
	int images_planned   = 0;
	int burst_left       = 0;
	int stall_run        = 0;
	int quiet_cycles     = 0;
	sink_mode_t sink_mode = SINK_OPEN;

	function automatic result_t make_item(input item_kind_t kind, input logic [31:0] cnt,
			input logic [31:0] pid, input logic [63:0] addr, input logic [15:0] len,
			input logic done, input logic valid);
		result_t r;
		r.item_kind    = kind;
		r.count_value  = cnt;
		r.product_id   = pid;
		r.item_address = addr;
		r.item_length  = len;
		r.scan_done    = done;
		r.image_valid  = done & valid;
		return r;
	endfunction

	// Advance the shadow scan by one pair; return how many items it yields
	function automatic int scan_pair(input pair_t pr, output result_t r0, output result_t r1);
		logic [31:0] cnt;
		logic [31:0] pid;
		logic [63:0] addr;
		logic        last;
		logic        verdict;
		r0 = '0;
		r1 = '0;
		if (pr.start_of_image) begin
			scan_phase      = PH_SEARCH;
			bytes_left      = stub_bytes;
			scan_key        = 32'd0;
			entry_count     = 2'd0;
			last_entry_zero = 1'b0;
		end
		// No room left or scan closed: drop the pair
		if (scan_phase == PH_DONE || bytes_left < PAIR_BYTES)
			return 0;
		bytes_left = bytes_left - PAIR_BYTES;
		addr = load_base + DOS_HDR + {48'd0, bytes_left};
		last = bytes_left < PAIR_BYTES;
		if (scan_phase == PH_SEARCH) begin
			r0 = make_item(KIND_PAD, pr.upper_word, pr.lower_word, addr, PAIR_BYTES, last, 1'b0);
			if (pr.lower_word == END_MARK) begin
				r0.item_kind = KIND_MASK;
				scan_key     = pr.upper_word;
				scan_phase   = PH_DECODE;
			end
			if (last)
				scan_phase = PH_DONE;
			return 1;
		end
		cnt = pr.upper_word ^ scan_key;
		pid = pr.lower_word ^ scan_key;
		if (pid == START_MARK) begin
			verdict = (entry_count != 2'd0) && last_entry_zero && (scan_key != 32'd0) &&
				(cnt == 32'd0);
			scan_phase = PH_DONE;
			r0 = make_item(KIND_START, cnt, pid, addr, PAIR_BYTES, 1'b1, verdict);
			// A valid header with stub bytes below it closes with a stub item instead
			if (verdict && bytes_left != 16'd0) begin
				r0.scan_done   = 1'b0;
				r0.image_valid = 1'b0;
				r1 = make_item(KIND_STUB, 32'd0, 32'd0, load_base + DOS_HDR, bytes_left,
					1'b1, 1'b1);
				return 2;
			end
			return 1;
		end
		if (entry_count != 2'd3)
			entry_count = entry_count + 2'd1;
		last_entry_zero = (cnt == 32'd0) && (pid == 32'd0);
		if (last)
			scan_phase = PH_DONE;
		r0 = make_item(KIND_ENTRY, cnt, pid, addr, PAIR_BYTES, last, 1'b0);
		return 1;
	endfunction

	function automatic void check_item(input result_t got, input result_t want);
		if (got.item_kind != want.item_kind) begin
			$error("item_kind: expected %0d, got %0d", want.item_kind, got.item_kind);
			mismatches++;
		end
		if (got.count_value != want.count_value) begin
			$error("count_value: expected %h, got %h", want.count_value, got.count_value);
			mismatches++;
		end
		if (got.product_id != want.product_id) begin
			$error("product_id: expected %h, got %h", want.product_id, got.product_id);
			mismatches++;
		end
		if (got.item_address != want.item_address) begin
			$error("item_address: expected %h, got %h", want.item_address, got.item_address);
			mismatches++;
		end
		if (got.item_length != want.item_length) begin
			$error("item_length: expected %0d, got %0d", want.item_length, got.item_length);
			mismatches++;
		end
		if (got.scan_done != want.scan_done) begin
			$error("scan_done: expected %0d, got %0d", want.scan_done, got.scan_done);
			mismatches++;
		end
		if (got.image_valid != want.image_valid) begin
			$error("image_valid: expected %0d, got %0d", want.image_valid, got.image_valid);
			mismatches++;
		end
	endfunction

	function automatic row_t cfg_row(input logic [63:0] base, input logic [15:0] stub);
		row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.base   = base;
		r.stub   = stub;
		return r;
	endfunction

	function automatic row_t pair_row(input logic sop, input logic [31:0] up,
			input logic [31:0] lo);
		row_t r;
		r = '0;
		r.st.pr.start_of_image = sop;
		r.st.pr.upper_word     = up;
		r.st.pr.lower_word     = lo;
		return r;
	endfunction

	function automatic row_t typed_row(input logic sop, input logic [31:0] up,
			input logic [31:0] lo, input bit [1:0] n, input result_t res);
		row_t r;
		r = pair_row(sop, up, lo);
		r.st.has_typed = 1'b1;
		r.st.typed_n   = n;
		r.st.typed_res = res;
		return r;
	endfunction

	function automatic logic [31:0] any_word();
		case ($urandom_range(0, 15))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return END_MARK;
			3: return START_MARK;
			default: return $urandom;
		endcase
	endfunction

	// Queue the pairs of one image in scan order: padding, mask marker, entries,
	// all-zero closer, start marker, then trailing pairs. Some images get broken
	// afterwards and a few are pure noise.
	function automatic void plan_image();
		int          style;
		int          first;
		int          pick;
		logic [31:0] key;
		logic [31:0] cnt;
		logic [31:0] pid;
		pair_t       p;
		style = $urandom_range(0, 19);
		first = image_pairs.size();
		if (style >= 17) begin
			repeat ($urandom_range(1, 8)) begin
				p.start_of_image = ($urandom_range(0, 3) == 0);
				p.upper_word     = any_word();
				p.lower_word     = any_word();
				image_pairs.push_back(p);
			end
			return;
		end
		key = ($urandom_range(0, 9) == 0) ? 32'h0 : any_word();
		p.start_of_image = 1'b1;
		repeat ($urandom_range(0, 3)) begin
			p.upper_word = ($urandom_range(0, 1) == 1) ? $urandom : 32'h0;
			p.lower_word = ($urandom_range(0, 1) == 1) ? $urandom : 32'h0;
			if (p.lower_word == END_MARK)
				p.lower_word = 32'h0;
			image_pairs.push_back(p);
			p.start_of_image = 1'b0;
		end
		p.upper_word = key;
		p.lower_word = END_MARK;
		image_pairs.push_back(p);
		p.start_of_image = 1'b0;
		repeat ($urandom_range(0, 4)) begin
			cnt = any_word();
			pid = any_word();
			if (pid == START_MARK)
				pid = pid ^ 32'h1;
			p.upper_word = cnt ^ key;
			p.lower_word = pid ^ key;
			image_pairs.push_back(p);
		end
		if ($urandom_range(0, 6) != 0) begin
			p.upper_word = key;
			p.lower_word = key;
			image_pairs.push_back(p);
		end
		cnt = ($urandom_range(0, 6) == 0) ? any_word() : 32'h0;
		p.upper_word = cnt ^ key;
		p.lower_word = START_MARK ^ key;
		image_pairs.push_back(p);
		repeat ($urandom_range(0, 2)) begin
			p.upper_word = any_word();
			p.lower_word = any_word();
			image_pairs.push_back(p);
		end
		if (style >= 14) begin
			pick = $urandom_range(first + 1, image_pairs.size() - 1);
			case ($urandom_range(0, 2))
				0: begin
					// cut the image short
					while (image_pairs.size() > pick)
						void'(image_pairs.pop_back());
				end
				1: begin
					p = image_pairs[pick];
					p.lower_word = p.lower_word ^ (32'h1 << $urandom_range(0, 31));
					image_pairs[pick] = p;
				end
				default: begin
					p = image_pairs[pick];
					p.start_of_image = ~p.start_of_image;
					image_pairs[pick] = p;
				end
			endcase
		end
	endfunction

	// Offer one pair; return at the edge where it is taken. Bursts end in a gap
	// so valid never drops and rises within one step.
	task automatic send_pair(input stim_t s);
		if (burst_left == 0) begin
			pair_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 12);
		end
		offered_stims.push_back(s);
		pair_ch.valid          <= 1'b1;
		pair_ch.start_of_image <= s.pr.start_of_image;
		pair_ch.upper_word     <= s.pr.upper_word;
		pair_ch.lower_word     <= s.pr.lower_word;
		do @(posedge clk); while (!(pair_ch.valid && pair_ch.ready));
		burst_left--;
	endtask

	// Hold the pair side, drain every due item, let ignored pairs clear the
	// pipeline, then write both registers back to back.
	task automatic write_config(input logic [63:0] base, input logic [15:0] stub);
		pair_ch.valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (items_due.size() != 0 || offered_stims.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BASE_ADDRESS;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= CFG_STUB_LENGTH;
		cfg_wdata <= {48'd0, stub};
		@(posedge clk);
		cfg_we <= 1'b0;
		load_base  = base;
		stub_bytes = stub;
		config_writes++;
	endtask

	// Predict on every pair transaction, check every result transaction, and
	// drive the result-side stall pattern.
	always @(posedge clk) begin : transaction_monitor
		stim_t   taken;
		result_t first_item;
		result_t second_item;
		result_t got;
		int      produced;
		if (arst_n) begin
			if (pair_ch.valid && pair_ch.ready && offered_stims.size() != 0) begin
				taken = offered_stims.pop_front();
				produced = scan_pair(taken.pr, first_item, second_item);
				// Hand-typed rows override the prediction
				if (taken.has_typed) begin
					produced   = taken.typed_n;
					first_item = taken.typed_res;
				end
				if (produced > 0) begin
					items_due.push_back(first_item);
					productive_pairs++;
				end
				if (produced > 1)
					items_due.push_back(second_item);
				pairs_taken++;
			end
			if (item_ch.valid && item_ch.ready) begin
				got = {item_ch.item_kind, item_ch.count_value, item_ch.product_id,
					item_ch.item_address, item_ch.item_length, item_ch.scan_done,
					item_ch.image_valid};
				items_checked++;
				if (items_due.size() == 0) begin
					$error("result with nothing due: kind %0d, address %h",
						item_ch.item_kind, item_ch.item_address);
					mismatches++;
				end else
					check_item(got, items_due.pop_front());
			end
			// Switch the stall pattern at the end of each random-length run
			if (stall_run == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				stall_run = $urandom_range(10, 80);
			end
			stall_run--;
			case (sink_mode)
				SINK_OPEN:   take_ready <= 1'b1;
				SINK_COIN:   take_ready <= ($urandom_range(0, 1) == 1);
				SINK_MOSTLY: take_ready <= ($urandom_range(0, 7) != 0);
				default:     take_ready <= (stall_run % 16) < 4;
			endcase
		end
	end

	// End the run when no transaction happens for too long
	always @(posedge clk) begin
		if (!arst_n || (pair_ch.valid && pair_ch.ready) || (item_ch.valid && item_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: %0d cycles without a transaction, %0d items still due",
				quiet_cycles, items_due.size());
			$display("[FAIL] regression broken");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		row_t        directed_rows[$];
		stim_t       st;
		logic [63:0] base;
		logic [15:0] stub;
		int          goal;

		pair_ch.valid          <= 1'b0;
		pair_ch.start_of_image <= 1'b0;
		pair_ch.upper_word     <= 32'd0;
		pair_ch.lower_word     <= 32'd0;
		load_base       = 64'd0;
		stub_bytes      = 16'd0;
		scan_phase      = PH_SEARCH;
		bytes_left      = 16'd0;
		scan_key        = 32'd0;
		entry_count     = 2'd0;
		last_entry_zero = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Registers at reset values: nothing before the first image start, and a
		// zero stub leaves no room at all
		directed_rows.push_back(typed_row(1'b0, 32'hFFFF_FFFF, END_MARK, 2'd0, '0));
		directed_rows.push_back(typed_row(1'b1, 32'h0, END_MARK, 2'd0, '0));
		// Top base so addresses wrap to the bare offset; a valid header that fills
		// the stub exactly
		directed_rows.push_back(cfg_row(64'hFFFF_FFFF_FFFF_FFC0, 16'd48));
		directed_rows.push_back(typed_row(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd1,
			make_item(KIND_PAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd40, PAIR_BYTES, 1'b0, 1'b0)));
		directed_rows.push_back(pair_row(1'b0, DIR_KEY, END_MARK));
		directed_rows.push_back(pair_row(1'b0, DIR_KEY ^ 32'h0003_00AB, DIR_KEY ^ 32'h0102_0304));
		directed_rows.push_back(pair_row(1'b0, ~DIR_KEY, ~DIR_KEY));
		directed_rows.push_back(pair_row(1'b0, DIR_KEY, DIR_KEY));
		directed_rows.push_back(pair_row(1'b0, DIR_KEY, DIR_KEY ^ START_MARK));
		directed_rows.push_back(typed_row(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0, '0));
		// Largest stub: zero mask gives no verdict; a restart without entries fails too
		directed_rows.push_back(cfg_row(64'd0, 16'hFFFF));
		directed_rows.push_back(pair_row(1'b1, 32'h0, END_MARK));
		directed_rows.push_back(pair_row(1'b0, 32'h0, 32'h0));
		directed_rows.push_back(pair_row(1'b0, 32'h0, START_MARK));
		directed_rows.push_back(pair_row(1'b1, 32'hFFFF_FFFF, END_MARK));
		directed_rows.push_back(pair_row(1'b0, 32'hFFFF_FFFA, ~START_MARK));
		// Odd stub that runs out while searching, then a pair with no room
		directed_rows.push_back(cfg_row(64'h1000, 16'd21));
		directed_rows.push_back(pair_row(1'b1, 32'hDEAD_BEEF, 32'h0));
		directed_rows.push_back(pair_row(1'b0, 32'h8000_0001, END_MARK));
		directed_rows.push_back(typed_row(1'b0, 32'h0, 32'h0, 2'd0, '0));
		// Odd stub whose remainder becomes the stub item
		directed_rows.push_back(cfg_row(64'h1000, 16'd29));
		directed_rows.push_back(pair_row(1'b1, 32'h8000_0001, END_MARK));
		directed_rows.push_back(pair_row(1'b0, 32'h8000_0001, 32'h8000_0001));
		directed_rows.push_back(pair_row(1'b0, 32'h8000_0001, 32'h8000_0001 ^ START_MARK));
		// Stub runs out while decoding entries
		directed_rows.push_back(cfg_row(64'h1000, 16'd16));
		directed_rows.push_back(pair_row(1'b1, 32'h7, END_MARK));
		directed_rows.push_back(pair_row(1'b0, 32'h6, 32'h5));
		// Exactly one pair of room, then less than one
		directed_rows.push_back(cfg_row(64'd0, 16'd8));
		directed_rows.push_back(typed_row(1'b1, 32'h0, 32'h0, 2'd1,
			make_item(KIND_PAD, 32'h0, 32'h0, 64'd64, PAIR_BYTES, 1'b1, 1'b0)));
		directed_rows.push_back(cfg_row(64'd0, 16'd7));
		directed_rows.push_back(typed_row(1'b1, 32'h0, END_MARK, 2'd0, '0));

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_config(directed_rows[i].base, directed_rows[i].stub);
			else
				send_pair(directed_rows[i].st);
		end

		// Random phases: new register setting, then a handful of images
		goal = pairs_taken + RANDOM_PAIRS;
		while (pairs_taken < goal) begin
			case ($urandom_range(0, 7))
				0: base = 64'd0;
				1: base = 64'hFFFF_FFFF_FFFF_FFFF;
				default: base = {$urandom, $urandom};
			endcase
			case ($urandom_range(0, 15))
				0: stub = 16'hFFFF;
				1: stub = 16'd0;
				2: stub = 16'($urandom_range(1, 7));
				default: stub = 16'($urandom_range(8, 200));
			endcase
			write_config(base, stub);
			repeat ($urandom_range(2, 6)) begin
				plan_image();
				images_planned++;
				while (image_pairs.size() != 0) begin
					st = '0;
					st.pr = image_pairs.pop_front();
					send_pair(st);
				end
			end
		end

		// Drain what is due, then watch a while longer for strays
		pair_ch.valid <= 1'b0;
		do @(posedge clk); while (items_due.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d pair transactions (%0d yielding items), %0d images, %0d settings.",
			pairs_taken, productive_pairs, images_planned, config_writes);
		$display("Compared %0d result transactions, %0d mismatches.", items_checked, mismatches);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
